/* hdl/qrs_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qrs_pkg
// Shared widths and result codes for the quadratic root solver.
// ----------------------------------------------------------------------------
package qrs_pkg;

  // root_kind codes
  localparam logic [1:0] KIND_NONE   = 2'd0;
  localparam logic [1:0] KIND_DOUBLE = 2'd1;
  localparam logic [1:0] KIND_DIST   = 2'd2;
  localparam logic [1:0] KIND_AZERO  = 2'd3;

  // discriminant b^2 - 4ac fits in 34 signed bits; its root in 17 bits
  localparam int RAD_W  = 34;
  localparam int ROOT_W = RAD_W / 2;
  // dividend |num| << 16 fits 33 bits, divisor |2a| fits 17 bits
  localparam int NUM_W  = 33;
  localparam int DEN_W  = 17;

endpackage

/* hdl/quadratic_root_solver.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quadratic_root_solver
// Roots of a*x^2 + b*x + c from Q8.8 coefficients, Q16.16 results.
// ----------------------------------------------------------------------------
// Fully pipelined: one coefficient request is taken every cycle unless the
// output stalls. The pipeline holds the square root (17 stages, one root bit
// each) and the divider (33 stages, one quotient bit each), plus two stages
// for the products and discriminant, one for the numerators and the output
// register. A stall at the output freezes the whole pipeline; nothing is
// dropped or repeated.
module quadratic_root_solver (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  output logic               stall_o,
  input  logic signed [15:0] a_coef_i,
  input  logic signed [15:0] b_coef_i,
  input  logic signed [15:0] c_coef_i,
  output logic               valid_o,
  input  logic               stall_i,
  output logic [1:0]         root_kind_o,
  output logic signed [31:0] root_plus_o,
  output logic signed [31:0] root_minus_o,
  output logic               saturated_o
);

  localparam int RAD_W  = qrs_pkg::RAD_W;
  localparam int ROOT_W = qrs_pkg::ROOT_W;
  localparam int NUM_W  = qrs_pkg::NUM_W;
  localparam int DEN_W  = qrs_pkg::DEN_W;

  logic adv;
  assign adv     = !(valid_o && stall_i);
  assign stall_o = !adv;

  // stage 1: products
  logic               v1_q;
  logic signed [31:0] bb_q, ac_q;
  logic signed [15:0] a1_q, b1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v1_q <= 1'b0;
    else if (adv) v1_q <= valid_i;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      bb_q <= b_coef_i * b_coef_i;
      ac_q <= a_coef_i * c_coef_i;
      a1_q <= a_coef_i;
      b1_q <= b_coef_i;
    end
  end

  // stage 2: discriminant and classification
  logic signed [RAD_W-1:0] disc_d;
  logic [1:0]              kind_d;
  logic                    v2_q;
  logic [RAD_W-1:0]        rad_q;
  logic [1:0]              kind2_q;
  logic signed [15:0]      a2_q, b2_q;

  always_comb begin
    disc_d = $signed({{2{bb_q[31]}}, bb_q}) - $signed({ac_q, 2'b00});
    if (a1_q == 16'sd0)       kind_d = qrs_pkg::KIND_AZERO;
    else if (disc_d < 0)      kind_d = qrs_pkg::KIND_NONE;
    else if (disc_d == 0)     kind_d = qrs_pkg::KIND_DOUBLE;
    else                      kind_d = qrs_pkg::KIND_DIST;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v2_q <= 1'b0;
    else if (adv) v2_q <= v1_q;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      rad_q   <= disc_d[RAD_W-1] ? '0 : disc_d;
      kind2_q <= kind_d;
      a2_q    <= a1_q;
      b2_q    <= b1_q;
    end
  end

  // square root pipeline, kind/a/b ride along
  logic              vs;
  logic [ROOT_W-1:0] root_s;
  logic [33:0]       side_s;

  qrs_isqrt #(.SIDE_W(34)) u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (v2_q),
    .rad_i   (rad_q),
    .side_i  ({kind2_q, a2_q, b2_q}),
    .valid_o (vs),
    .root_o  (root_s),
    .side_o  (side_s)
  );

  // stage: numerators -b +/- s, magnitudes and signs
  logic signed [15:0] as, bs;
  logic signed [17:0] nump, numm;
  logic [15:0]        abs_a;
  logic [16:0]        mag_p, mag_m;
  logic               v3_q;
  logic [NUM_W-1:0]   np_q, nm_q;
  logic [DEN_W-1:0]   den_q;
  logic [3:0]         side3_q;

  always_comb begin
    as    = side_s[31:16];
    bs    = side_s[15:0];
    nump  = -18'(bs) + $signed({1'b0, root_s});
    numm  = -18'(bs) - $signed({1'b0, root_s});
    abs_a = as[15] ? 16'(-as) : as;
    mag_p = nump[17] ? 17'(-nump) : nump[16:0];
    mag_m = numm[17] ? 17'(-numm) : numm[16:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v3_q <= 1'b0;
    else if (adv) v3_q <= vs;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      np_q    <= {mag_p, 16'h0000};
      nm_q    <= {mag_m, 16'h0000};
      den_q   <= {abs_a, 1'b0};
      side3_q <= {side_s[33:32], nump[17] ^ as[15], numm[17] ^ as[15]};
    end
  end

  // divider pipeline
  logic             vd;
  logic [NUM_W-1:0] qp, qm;
  logic [3:0]       side_dv;

  qrs_div #(.SIDE_W(4)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (v3_q),
    .num_p_i (np_q),
    .num_m_i (nm_q),
    .den_i   (den_q),
    .side_i  (side3_q),
    .valid_o (vd),
    .quo_p_o (qp),
    .quo_m_o (qm),
    .side_o  (side_dv)
  );

  // clamp to Q16.16, mask roots for no-root and degenerate cases
  logic [1:0]  kind_f;
  logic        sat_p, sat_m, has_roots;
  logic [31:0] rp_d, rm_d;

  always_comb begin
    kind_f    = side_dv[3:2];
    has_roots = (kind_f == qrs_pkg::KIND_DOUBLE) || (kind_f == qrs_pkg::KIND_DIST);
    sat_p = side_dv[1] ? (qp > 33'h080000000) : (qp > 33'h07FFFFFFF);
    sat_m = side_dv[0] ? (qm > 33'h080000000) : (qm > 33'h07FFFFFFF);
    if (side_dv[1]) rp_d = sat_p ? 32'h80000000 : 32'(-qp[31:0]);
    else            rp_d = sat_p ? 32'h7FFFFFFF : qp[31:0];
    if (side_dv[0]) rm_d = sat_m ? 32'h80000000 : 32'(-qm[31:0]);
    else            rm_d = sat_m ? 32'h7FFFFFFF : qm[31:0];
    if (!has_roots) begin
      rp_d  = '0;
      rm_d  = '0;
      sat_p = 1'b0;
      sat_m = 1'b0;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) valid_o <= 1'b0;
    else if (adv) valid_o <= vd;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      root_kind_o  <= kind_f;
      root_plus_o  <= rp_d;
      root_minus_o <= rm_d;
      saturated_o  <= sat_p | sat_m;
    end
  end

endmodule

/* hdl/qrs_isqrt.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qrs_isqrt
// Pipelined floor square root, one result bit per stage, with a side word
// and a valid bit carried alongside.
// ----------------------------------------------------------------------------
module qrs_isqrt #(
  parameter int SIDE_W = 34
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  logic                       valid_i,
  input  logic [qrs_pkg::RAD_W-1:0]  rad_i,
  input  logic [SIDE_W-1:0]          side_i,
  output logic                       valid_o,
  output logic [qrs_pkg::ROOT_W-1:0] root_o,
  output logic [SIDE_W-1:0]          side_o
);

  localparam int N     = qrs_pkg::ROOT_W;
  localparam int REM_W = N + 1;

  // stage k inputs, and the register after stage k
  logic [N-1:0]                    vld_in;
  logic [qrs_pkg::RAD_W-1:0]       rad_in  [N];
  logic [REM_W-1:0]                rem_in  [N];
  logic [N-1:0]                    root_in [N];
  logic [SIDE_W-1:0]               side_in [N];
  logic [N-1:0]                    vld_q;
  logic [qrs_pkg::RAD_W-1:0]       rad_q  [N];
  logic [REM_W-1:0]                rem_q  [N];
  logic [N-1:0]                    root_q [N];
  logic [SIDE_W-1:0]               side_q [N];
  logic [qrs_pkg::RAD_W-1:0]       rad_d  [N];
  logic [REM_W-1:0]                rem_d  [N];
  logic [N-1:0]                    root_d [N];

  // stage 0 takes the incoming request, later stages the previous register
  always_comb begin
    rad_in[0]  = rad_i;
    rem_in[0]  = '0;
    root_in[0] = '0;
    side_in[0] = side_i;
    vld_in[0]  = valid_i;
    for (int k = 1; k < N; k++) begin
      rad_in[k]  = rad_q[k-1];
      rem_in[k]  = rem_q[k-1];
      root_in[k] = root_q[k-1];
      side_in[k] = side_q[k-1];
      vld_in[k]  = vld_q[k-1];
    end
  end

  // one digit pair per stage
  always_comb begin
    logic [REM_W+1:0] r4;
    logic [REM_W+1:0] trial;
    logic             ge;
    for (int k = 0; k < N; k++) begin
      r4    = {rem_in[k], rad_in[k][qrs_pkg::RAD_W-1 -: 2]};
      trial = {1'b0, root_in[k], 2'b01};
      ge    = (r4 >= trial);
      rem_d[k]  = ge ? REM_W'(r4 - trial) : REM_W'(r4);
      root_d[k] = {root_in[k][N-2:0], ge};
      rad_d[k]  = {rad_in[k][qrs_pkg::RAD_W-3:0], 2'b00};
    end
  end

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= vld_in;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < N; k++) begin
        rad_q[k]  <= rad_d[k];
        rem_q[k]  <= rem_d[k];
        root_q[k] <= root_d[k];
        side_q[k] <= side_in[k];
      end
    end
  end

  assign valid_o = vld_q[N-1];
  assign root_o  = root_q[N-1];
  assign side_o  = side_q[N-1];

endmodule

/* hdl/qrs_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qrs_div
// Two-lane pipelined restoring divider sharing one divisor, one quotient
// bit per stage, with a side word and valid bit carried alongside.
// ----------------------------------------------------------------------------
module qrs_div #(
  parameter int SIDE_W = 4
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic                      valid_i,
  input  logic [qrs_pkg::NUM_W-1:0] num_p_i,
  input  logic [qrs_pkg::NUM_W-1:0] num_m_i,
  input  logic [qrs_pkg::DEN_W-1:0] den_i,
  input  logic [SIDE_W-1:0]         side_i,
  output logic                      valid_o,
  output logic [qrs_pkg::NUM_W-1:0] quo_p_o,
  output logic [qrs_pkg::NUM_W-1:0] quo_m_o,
  output logic [SIDE_W-1:0]         side_o
);

  localparam int N  = qrs_pkg::NUM_W;
  localparam int DW = qrs_pkg::DEN_W;

  // stage k inputs, and the register after stage k
  logic [N-1:0]      vld_in;
  logic [N-1:0]      np_in  [N];
  logic [N-1:0]      nm_in  [N];
  logic [DW-1:0]     rp_in  [N];
  logic [DW-1:0]     rm_in  [N];
  logic [N-1:0]      qp_in  [N];
  logic [N-1:0]      qm_in  [N];
  logic [DW-1:0]     den_in [N];
  logic [SIDE_W-1:0] side_in[N];
  logic [N-1:0]      vld_q;
  logic [N-1:0]      np_q  [N];
  logic [N-1:0]      nm_q  [N];
  logic [DW-1:0]     rp_q  [N];
  logic [DW-1:0]     rm_q  [N];
  logic [N-1:0]      qp_q  [N];
  logic [N-1:0]      qm_q  [N];
  logic [DW-1:0]     den_q [N];
  logic [SIDE_W-1:0] side_q[N];
  logic [DW-1:0]     rp_d  [N];
  logic [DW-1:0]     rm_d  [N];
  logic [N-1:0]      qp_d  [N];
  logic [N-1:0]      qm_d  [N];

  // stage 0 takes the incoming request, later stages the previous register
  always_comb begin
    vld_in[0]  = valid_i;
    np_in[0]   = num_p_i;
    nm_in[0]   = num_m_i;
    rp_in[0]   = '0;
    rm_in[0]   = '0;
    qp_in[0]   = '0;
    qm_in[0]   = '0;
    den_in[0]  = den_i;
    side_in[0] = side_i;
    for (int k = 1; k < N; k++) begin
      vld_in[k]  = vld_q[k-1];
      np_in[k]   = np_q[k-1];
      nm_in[k]   = nm_q[k-1];
      rp_in[k]   = rp_q[k-1];
      rm_in[k]   = rm_q[k-1];
      qp_in[k]   = qp_q[k-1];
      qm_in[k]   = qm_q[k-1];
      den_in[k]  = den_q[k-1];
      side_in[k] = side_q[k-1];
    end
  end

  // shift in one dividend bit, subtract if it fits
  always_comb begin
    logic [DW:0] r2p;
    logic [DW:0] r2m;
    logic        gep;
    logic        gem;
    for (int k = 0; k < N; k++) begin
      r2p = {rp_in[k], np_in[k][N-1]};
      r2m = {rm_in[k], nm_in[k][N-1]};
      gep = (r2p >= {1'b0, den_in[k]});
      gem = (r2m >= {1'b0, den_in[k]});
      rp_d[k] = gep ? DW'(r2p - {1'b0, den_in[k]}) : DW'(r2p);
      rm_d[k] = gem ? DW'(r2m - {1'b0, den_in[k]}) : DW'(r2m);
      qp_d[k] = {qp_in[k][N-2:0], gep};
      qm_d[k] = {qm_in[k][N-2:0], gem};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= vld_in;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < N; k++) begin
        np_q[k]   <= {np_in[k][N-2:0], 1'b0};
        nm_q[k]   <= {nm_in[k][N-2:0], 1'b0};
        rp_q[k]   <= rp_d[k];
        rm_q[k]   <= rm_d[k];
        qp_q[k]   <= qp_d[k];
        qm_q[k]   <= qm_d[k];
        den_q[k]  <= den_in[k];
        side_q[k] <= side_in[k];
      end
    end
  end

  assign valid_o = vld_q[N-1];
  assign quo_p_o = qp_q[N-1];
  assign quo_m_o = qm_q[N-1];
  assign side_o  = side_q[N-1];

endmodule

/* verif/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the quadratic root solver.
// ----------------------------------------------------------------------------
// Coefficient requests are driven through the valid/stall handshake. Every
// accepted request is solved in the bench (exact discriminant, floored square
// root, truncating divide, Q16.16 clamp). Each result from the block is
// compared field by field against the oldest pending solution. Both sides
// idle in random bursts, except in the final stretch of the run.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int LATENCY   = 54;
  localparam int WDOG_MAX  = 20000;
  localparam int N_RANDOM  = 1800;

  typedef struct packed {
    logic [1:0]         kind;
    logic signed [31:0] rplus;
    logic signed [31:0] rminus;
    logic               sat;
  } roots_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               valid_i = 1'b0;
  logic               stall_o;
  logic signed [15:0] a_coef_i = '0;
  logic signed [15:0] b_coef_i = '0;
  logic signed [15:0] c_coef_i = '0;
  logic               valid_o;
  logic               stall_i = 1'b0;
  logic [1:0]         root_kind_o;
  logic signed [31:0] root_plus_o;
  logic signed [31:0] root_minus_o;
  logic               saturated_o;

  roots_t pending_roots[$];
  int     mismatch_cnt = 0;
  int     idle_cycles  = 0;
  bit     send_idle    = 1'b1;
  bit     sink_idle    = 1'b1;

  quadratic_root_solver i_dut (.*);

  // clock
  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // (num << 16) / den, truncated toward zero, clamped to Q16.16
  function automatic logic signed [31:0] q16_div(input longint num, input longint den,
                                                 inout logic sat);
    longint q;
    q = (num * 65536) / den;
    if (q > 64'sd2147483647) begin
      sat = 1'b1;
      return 32'sh7FFFFFFF;
    end
    if (q < -64'sd2147483648) begin
      sat = 1'b1;
      return 32'sh80000000;
    end
    return q[31:0];
  endfunction

  function automatic longint floor_sqrt(input longint v);
    longint r;
    r = 0;
    for (int bitpos = 17; bitpos >= 0; bitpos--) begin
      if ((r + (64'sd1 << bitpos)) * (r + (64'sd1 << bitpos)) <= v)
        r = r + (64'sd1 << bitpos);
    end
    return r;
  endfunction

  function automatic roots_t solve_roots(input logic signed [15:0] a,
                                         input logic signed [15:0] b,
                                         input logic signed [15:0] c);
    roots_t r;
    longint av, bv, cv, disc, s;
    logic   sat;
    av = a; bv = b; cv = c;
    sat = 1'b0;
    r = '0;
    if (av == 0) begin
      r.kind = qrs_pkg::KIND_AZERO;
    end else begin
      disc = bv * bv - 4 * av * cv;
      if (disc < 0) begin
        r.kind = qrs_pkg::KIND_NONE;
      end else if (disc == 0) begin
        r.kind = qrs_pkg::KIND_DOUBLE;
        r.rplus = q16_div(-bv, 2 * av, sat);
        r.rminus = r.rplus;
      end else begin
        s = floor_sqrt(disc);
        r.kind = qrs_pkg::KIND_DIST;
        r.rplus = q16_div(-bv + s, 2 * av, sat);
        r.rminus = q16_div(-bv - s, 2 * av, sat);
      end
    end
    r.sat = sat;
    return r;
  endfunction

  // drive one request, holding it until accepted; optional idle burst first
  task automatic send_coefs(input logic signed [15:0] a, input logic signed [15:0] b,
                            input logic signed [15:0] c);
    if (send_idle && $urandom_range(0, 5) == 0) begin
      valid_i <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk_i);
    end
    valid_i  <= 1'b1;
    a_coef_i <= a;
    b_coef_i <= b;
    c_coef_i <= c;
    @(posedge clk_i);
    while (stall_o) @(posedge clk_i);
    pending_roots.push_back(solve_roots(a, b, c));
  endtask

  task automatic release_bus();
    valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // extremes of every field, each root kind and clamping
  task automatic test_directed();
    send_coefs(16'sh0000, 16'sh0100, 16'sh0100);
    send_coefs(16'sh0100, 16'sh0000, 16'sh0100);
    send_coefs(16'sh0100, -16'sh0200, 16'sh0100);
    send_coefs(16'sh0100, 16'sh0000, -16'sh0400);
    send_coefs(16'sh0001, 16'sh7FFF, 16'sh0000);
    send_coefs(16'sh0001, 16'sh8000, 16'sh0000);
    send_coefs(16'sh8000, 16'sh8000, 16'sh8000);
    send_coefs(16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
    send_coefs(16'sh8000, 16'sh7FFF, 16'sh7FFF);
    send_coefs(16'sh7FFF, 16'sh8000, 16'sh8000);
    send_coefs(16'sh0001, 16'sh0000, 16'sh8000);
    send_coefs(-16'sh0001, 16'sh0000, 16'sh7FFF);
    send_coefs(16'sh0001, 16'sh0002, 16'sh0001);
    send_coefs(16'shFFFF, 16'shFFFF, 16'shFFFF);
    send_coefs(16'sh0000, 16'sh0000, 16'sh0000);
    send_coefs(16'sh0001, 16'sh0000, 16'sh0000);
    send_coefs(16'sh5555, 16'shAAAA, 16'sh5555);
    send_coefs(16'shAAAA, 16'sh5555, 16'shAAAA);
    release_bus();
  endtask

  // pause the sender until the pipe has drained
  task automatic test_drain_pause();
    while (pending_roots.size() != 0) @(posedge clk_i);
    send_coefs(16'sh0100, 16'sh0300, 16'sh0200);
    release_bus();
  endtask

  function automatic logic signed [15:0] rand_coef();
    case ($urandom_range(0, 5))
      0:       return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
      1:       return $signed(16'($urandom_range(0, 64))) - 16'sd32;
      default: return 16'($urandom);
    endcase
  endfunction

  // random coefficients; some built as perfect squares for double roots
  task automatic test_random(input int n);
    logic signed [15:0] a, b, c;
    for (int i = 0; i < n; i++) begin
      a = rand_coef();
      c = rand_coef();
      b = rand_coef();
      if ($urandom_range(0, 7) == 0) begin
        // a = p^2, c = q^2, b = 2pq gives D = 0
        a = $signed(16'($urandom_range(1, 127)));
        c = $signed(16'($urandom_range(0, 127)));
        b = 16'(2 * floor_sqrt(longint'(a)) * floor_sqrt(longint'(c)));
        a = 16'(floor_sqrt(longint'(a)) ** 2);
        c = 16'(floor_sqrt(longint'(c)) ** 2);
        if ($urandom_range(0, 1)) b = -b;
      end
      if (i > n - n / 8) begin
        send_idle = 1'b0;
        sink_idle = 1'b0;
      end
      send_coefs(a, b, c);
    end
    release_bus();
  endtask

  // result checker and receiver back-pressure
  always @(posedge clk_i) begin
    roots_t exp_r;
    if (valid_o && !stall_i) begin
      if (pending_roots.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10) $display("unexpected result, kind %0d", root_kind_o);
      end else begin
        exp_r = pending_roots.pop_front();
        if (exp_r.kind !== root_kind_o || exp_r.rplus !== root_plus_o ||
            exp_r.rminus !== root_minus_o || exp_r.sat !== saturated_o) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("mismatch: exp kind %0d +%0d -%0d sat %0d, got %0d +%0d -%0d sat %0d",
                     exp_r.kind, exp_r.rplus, exp_r.rminus, exp_r.sat, root_kind_o,
                     root_plus_o, root_minus_o, saturated_o);
        end
      end
    end
    if (sink_idle && !stall_i && $urandom_range(0, 7) == 0) stall_i <= 1'b1;
    else if (stall_i && (!sink_idle || $urandom_range(0, 3) == 0)) stall_i <= 1'b0;
  end

  // watchdog on cycles with no handshake
  always @(posedge clk_i) begin
    if ((valid_i && !stall_o) || (valid_o && !stall_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WDOG_MAX) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_drain_pause();
    test_random(N_RANDOM);
    while (pending_roots.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 10) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

/* sim.f */
hdl/qrs_pkg.sv
hdl/qrs_isqrt.sv
hdl/qrs_div.sv
hdl/quadratic_root_solver.sv
verif/tb_top.sv
